// ----- rtl/rbq_pkg.sv -----
package rbq_pkg;

   // Number of batch slots in the table.
   localparam int QUEUE_DEPTH = 12;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Fixed field widths of the item channels.
   localparam int MODE_W  = 2;
   localparam int SEQ_W   = 32;
   localparam int SLOT_W  = 4;
   localparam int ATT_W   = 8;
   localparam int PEND_W  = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQUEUE = 2'd0,
      MODE_ACK     = 2'd1,
      MODE_SELECT  = 2'd2,
      MODE_UNUSED  = 2'd3
   } rbq_mode_type;

   // Controller to datapath.
   typedef struct packed {
      logic start;   // latch item, clear scan state
      logic step;    // examine one slot
      logic commit;  // apply update, load result register
   } rbq_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic scan_last;
   } rbq_stat_type;

endpackage

// ----- rtl/rbq_if.sv -----
interface rbq_req_if;
   import rbq_pkg::*;

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [SEQ_W-1:0]   ack_sequence;
   logic               catchup_frame;

   modport source (output valid, output mode, output ack_sequence, output catchup_frame,
                   input ready);
   modport sink   (input valid, input mode, input ack_sequence, input catchup_frame,
                   output ready);
endinterface

interface rbq_rsp_if;
   import rbq_pkg::*;

   logic               valid;
   logic               ready;
   logic [SLOT_W-1:0]  slot_index;
   logic [SEQ_W-1:0]   batch_sequence;
   logic               hit;
   logic               dropped_oldest;
   logic               backfill;
   logic [ATT_W-1:0]   attempt_count;
   logic [PEND_W-1:0]  pending_count;

   modport source (output valid, output slot_index, output batch_sequence, output hit,
                   output dropped_oldest, output backfill, output attempt_count,
                   output pending_count, input ready);
   modport sink   (input valid, input slot_index, input batch_sequence, input hit,
                   input dropped_oldest, input backfill, input attempt_count,
                   input pending_count, output ready);
endinterface

// ----- rtl/retransmit_batch_queue_core.sv -----
// An accepted item is scanned slot by slot, then committed to the result register; the commit
//   waits while an earlier result is held there and not being taken.
// A new item is accepted only in idle, after the previous one has committed.
// A finished result may wait in the output register while the next item is scanned.
// Reset (synchronous, active high): all slots free, next sequence 1, no result pending.
module retransmit_batch_queue_core (
   input  logic   clock,
   input  logic   reset,
   rbq_req_if.sink   req_bus,
   rbq_rsp_if.source rsp_bus
);
   import rbq_pkg::*;

   rbq_cmd_type  cmd;
   rbq_stat_type stat;

   // Controller: idle / scan / commit sequencer, owns the handshakes.
   rbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: slot table, scan trackers (first free, first ack match,
   // oldest, newest), update logic and the result register.
   rbq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .in_mode            (req_bus.mode),
      .in_ack_sequence    (req_bus.ack_sequence),
      .in_catchup_frame   (req_bus.catchup_frame),
      .out_slot_index     (rsp_bus.slot_index),
      .out_batch_sequence (rsp_bus.batch_sequence),
      .out_hit            (rsp_bus.hit),
      .out_dropped_oldest (rsp_bus.dropped_oldest),
      .out_backfill       (rsp_bus.backfill),
      .out_attempt_count  (rsp_bus.attempt_count),
      .out_pending_count  (rsp_bus.pending_count)
   );

endmodule

// ----- rtl/rbq_ctrl.sv -----
module rbq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rbq_pkg::rbq_stat_type stat,
   output rbq_pkg::rbq_cmd_type  cmd
);
   import rbq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.start  = req_ready && req_valid;
   assign cmd.step   = (state_ff == ST_SCAN);
   assign cmd.commit = (state_ff == ST_COMMIT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result replaces one that drains in the same cycle
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (stat.scan_last) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               // result register must be empty or draining this cycle
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- rtl/rbq_datapath.sv -----
module rbq_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  rbq_pkg::rbq_cmd_type          cmd,
   output rbq_pkg::rbq_stat_type         stat,
   input  logic [rbq_pkg::MODE_W-1:0]    in_mode,
   input  logic [rbq_pkg::SEQ_W-1:0]     in_ack_sequence,
   input  logic                          in_catchup_frame,
   output logic [rbq_pkg::SLOT_W-1:0]    out_slot_index,
   output logic [rbq_pkg::SEQ_W-1:0]     out_batch_sequence,
   output logic                          out_hit,
   output logic                          out_dropped_oldest,
   output logic                          out_backfill,
   output logic [rbq_pkg::ATT_W-1:0]     out_attempt_count,
   output logic [rbq_pkg::PEND_W-1:0]    out_pending_count
);
   import rbq_pkg::*;

   // Slot table
   logic [QUEUE_DEPTH-1:0] active_ff;
   logic [SEQ_W-1:0]       seq_mem_ff [QUEUE_DEPTH];
   logic [ATT_W-1:0]       att_mem_ff [QUEUE_DEPTH];
   logic [SEQ_W-1:0]       next_seq_ff;
   logic [SEQ_W-1:0]       next_seq_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   // Latched item
   rbq_mode_type           mode_ff;
   logic [SEQ_W-1:0]       ack_seq_ff;
   logic                   catchup_ff;

   // Scan state
   logic [IDX_W-1:0]       scan_idx_ff;
   logic                   free_found_ff;
   logic [IDX_W-1:0]       free_idx_ff;
   logic                   match_found_ff;
   logic [IDX_W-1:0]       match_idx_ff;
   logic [ATT_W-1:0]       match_att_ff;
   logic                   min_found_ff;
   logic [IDX_W-1:0]       min_idx_ff;
   logic [SEQ_W-1:0]       min_seq_ff;
   logic [ATT_W-1:0]       min_att_ff;
   logic                   max_found_ff;
   logic [IDX_W-1:0]       max_idx_ff;
   logic [SEQ_W-1:0]       max_seq_ff;
   logic [ATT_W-1:0]       max_att_ff;

   // Result register
   logic [SLOT_W-1:0]      res_slot_ff;
   logic [SEQ_W-1:0]       res_seq_ff;
   logic                   res_hit_ff;
   logic                   res_drop_ff;
   logic                   res_back_ff;
   logic [ATT_W-1:0]       res_att_ff;
   logic [PEND_W-1:0]      res_pend_ff;

   // Scan step
   logic                   rd_active;
   logic [SEQ_W-1:0]       rd_seq;
   logic [ATT_W-1:0]       rd_att;
   logic                   take_free;
   logic                   take_match;
   logic                   take_min;
   logic                   take_max;

   // Commit
   logic                   wr_seq_en;
   logic                   wr_att_en;
   logic                   set_active;
   logic                   clr_active;
   logic [IDX_W-1:0]       wr_idx;
   logic [ATT_W-1:0]       wr_att;
   logic                   sel_old;
   logic                   sel_found;
   logic [IDX_W-1:0]       sel_idx;
   logic [SEQ_W-1:0]       sel_seq;
   logic [ATT_W-1:0]       sel_att;
   logic [SLOT_W-1:0]      res_slot_in;
   logic [SEQ_W-1:0]       res_seq_in;
   logic                   res_hit_in;
   logic                   res_drop_in;
   logic                   res_back_in;
   logic [ATT_W-1:0]       res_att_in;

   assign stat.scan_last = (scan_idx_ff == IDX_W'(QUEUE_DEPTH - 1));

   assign rd_active = active_ff[scan_idx_ff];
   assign rd_seq    = seq_mem_ff[scan_idx_ff];
   assign rd_att    = att_mem_ff[scan_idx_ff];

   // strict compares keep the lowest slot on equal sequences
   assign take_free  = !free_found_ff && !rd_active;
   assign take_match = !match_found_ff && rd_active && (rd_seq == ack_seq_ff);
   assign take_min   = rd_active && (!min_found_ff || (rd_seq < min_seq_ff));
   assign take_max   = rd_active && (!max_found_ff || (rd_seq > max_seq_ff));

   always_comb begin
      wr_seq_en   = 1'b0;
      wr_att_en   = 1'b0;
      set_active  = 1'b0;
      clr_active  = 1'b0;
      wr_idx      = '0;
      wr_att      = '0;
      next_seq_in = next_seq_ff;
      count_in    = count_ff;
      res_slot_in = '0;
      res_seq_in  = '0;
      res_hit_in  = 1'b0;
      res_drop_in = 1'b0;
      res_back_in = 1'b0;
      res_att_in  = '0;
      sel_old     = catchup_ff && (count_ff > CNT_W'(1));
      sel_found   = sel_old ? min_found_ff : max_found_ff;
      sel_idx     = sel_old ? min_idx_ff   : max_idx_ff;
      sel_seq     = sel_old ? min_seq_ff   : max_seq_ff;
      sel_att     = sel_old ? min_att_ff   : max_att_ff;
      unique case (mode_ff)
         MODE_ENQUEUE: begin
            wr_seq_en   = 1'b1;
            wr_att_en   = 1'b1;
            set_active  = 1'b1;
            next_seq_in = next_seq_ff + SEQ_W'(1);
            if (free_found_ff) begin
               wr_idx   = free_idx_ff;
               count_in = count_ff + CNT_W'(1);
            end else begin
               // table full: overwrite the oldest batch
               wr_idx      = min_idx_ff;
               res_drop_in = 1'b1;
            end
            res_slot_in = SLOT_W'(wr_idx);
            res_seq_in  = next_seq_ff;
            res_hit_in  = 1'b1;
         end
         MODE_ACK: begin
            if (match_found_ff) begin
               wr_idx      = match_idx_ff;
               clr_active  = 1'b1;
               count_in    = count_ff - CNT_W'(1);
               res_slot_in = SLOT_W'(match_idx_ff);
               res_seq_in  = ack_seq_ff;
               res_att_in  = match_att_ff;
               res_hit_in  = 1'b1;
            end
         end
         MODE_SELECT: begin
            if (sel_found) begin
               wr_idx      = sel_idx;
               wr_att_en   = 1'b1;
               wr_att      = (sel_att == '1) ? sel_att : sel_att + ATT_W'(1);
               res_slot_in = SLOT_W'(sel_idx);
               res_seq_in  = sel_seq;
               res_att_in  = wr_att;
               res_back_in = sel_old;
               res_hit_in  = 1'b1;
            end
         end
         MODE_UNUSED: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         next_seq_ff <= SEQ_W'(1);
         count_ff    <= '0;
      end else if (cmd.commit) begin
         next_seq_ff <= next_seq_in;
         count_ff    <= count_in;
         if (set_active) begin
            active_ff[wr_idx] <= 1'b1;
         end
         if (clr_active) begin
            active_ff[wr_idx] <= 1'b0;
         end
      end
   end

   // Table payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (wr_seq_en) begin
            seq_mem_ff[wr_idx] <= next_seq_ff;
         end
         if (wr_att_en) begin
            att_mem_ff[wr_idx] <= wr_att;
         end
      end
   end

   // Item latch and scan
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff        <= rbq_mode_type'(in_mode);
         ack_seq_ff     <= in_ack_sequence;
         catchup_ff     <= in_catchup_frame;
         scan_idx_ff    <= '0;
         free_found_ff  <= 1'b0;
         match_found_ff <= 1'b0;
         min_found_ff   <= 1'b0;
         max_found_ff   <= 1'b0;
      end else if (cmd.step) begin
         if (!stat.scan_last) begin
            scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         end
         if (take_free) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= scan_idx_ff;
         end
         if (take_match) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= scan_idx_ff;
            match_att_ff   <= rd_att;
         end
         if (take_min) begin
            min_found_ff <= 1'b1;
            min_idx_ff   <= scan_idx_ff;
            min_seq_ff   <= rd_seq;
            min_att_ff   <= rd_att;
         end
         if (take_max) begin
            max_found_ff <= 1'b1;
            max_idx_ff   <= scan_idx_ff;
            max_seq_ff   <= rd_seq;
            max_att_ff   <= rd_att;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_slot_ff <= res_slot_in;
         res_seq_ff  <= res_seq_in;
         res_hit_ff  <= res_hit_in;
         res_drop_ff <= res_drop_in;
         res_back_ff <= res_back_in;
         res_att_ff  <= res_att_in;
         res_pend_ff <= PEND_W'(count_in);
      end
   end

   assign out_slot_index     = res_slot_ff;
   assign out_batch_sequence = res_seq_ff;
   assign out_hit            = res_hit_ff;
   assign out_dropped_oldest = res_drop_ff;
   assign out_backfill       = res_back_ff;
   assign out_attempt_count  = res_att_ff;
   assign out_pending_count  = res_pend_ff;

endmodule
